// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the track angle RTL.
// Each macro expands to one labelled concurrent assertion with an asynchronous reset guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in a cycle implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// Antecedent in a cycle implies consequent after the delay given as dly.
`define ASSERT_DELAYED(label, clk, rst_n, ante, dly, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##dly (cons)) \
		else $error("assertion failed: delayed response");

`endif

// ===== rtl/core/tafv_pkg.sv =====
// Package for the track angle block: widths, arctangent table and pipeline control type.
// No dependencies; every module of the block imports it.
`timescale 1ns / 1ps

package tafv_pkg;

	// Defaults for the top level parameters.
	localparam int SPEED_WIDTH_DEF = 16;
	localparam int ANGLE_WIDTH_DEF = 16;

	// Fixed arithmetic choices of the rotation unit.
	localparam int CORDIC_STEPS = 30;
	localparam int GUARD_BITS   = 24;
	localparam int ZACC_WIDTH   = 32;
	localparam int HEADROOM     = 3;

	// Half a turn in the internal angle accumulator.
	localparam logic [ZACC_WIDTH-1:0] HALF_TURN = 32'h8000_0000;

	// atan(2^-i) scaled so that 2^32 counts are a full turn, rounded to nearest.
	localparam logic [ZACC_WIDTH-1:0] ATAN_TABLE [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	// Control that travels alongside each word in the pipeline.
	typedef struct packed {
		logic valid;
		logic zero;
	} ctrl_t;

endpackage

// ===== rtl/core/tafv_prep.sv =====
// Entry stage: scales the velocity word and folds the lower half plane onto the upper one.
// Depends on tafv_pkg for the guard width, the half turn and the control type.
`timescale 1ns / 1ps

module tafv_prep #(
	parameter int SPEED_WIDTH = tafv_pkg::SPEED_WIDTH_DEF,
	parameter int VEC_WIDTH   = SPEED_WIDTH + tafv_pkg::GUARD_BITS + tafv_pkg::HEADROOM
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   accept,
	input  logic signed [SPEED_WIDTH-1:0]          east_speed,
	input  logic signed [SPEED_WIDTH-1:0]          north_speed,
	output tafv_pkg::ctrl_t                        ctrl_out,
	output logic signed [VEC_WIDTH-1:0]            e_out,
	output logic signed [VEC_WIDTH-1:0]            n_out,
	output logic [tafv_pkg::ZACC_WIDTH-1:0]        z_out
);
	import tafv_pkg::*;

	localparam int EXT_BITS = VEC_WIDTH - SPEED_WIDTH - GUARD_BITS;

	logic signed [VEC_WIDTH-1:0] e_ext;
	logic signed [VEC_WIDTH-1:0] n_ext;
	logic                        is_zero;
	ctrl_t                       ctrl_s1;
	logic signed [VEC_WIDTH-1:0] e_s1;
	logic signed [VEC_WIDTH-1:0] n_s1;
	logic [ZACC_WIDTH-1:0]       z_s1;

	// Sign-extend and scale up by the guard bits.
	assign e_ext   = {{EXT_BITS{east_speed[SPEED_WIDTH-1]}}, east_speed, {GUARD_BITS{1'b0}}};
	assign n_ext   = {{EXT_BITS{north_speed[SPEED_WIDTH-1]}}, north_speed, {GUARD_BITS{1'b0}}};
	assign is_zero = (east_speed == '0) && (north_speed == '0);

	// Control register of the entry stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1.valid <= accept;
			ctrl_s1.zero  <= accept && is_zero;
		end
	end

	// A southward vector is turned by half a turn before the rotations.
	always_ff @(posedge clk) begin
		if (north_speed[SPEED_WIDTH-1]) begin
			e_s1 <= -e_ext;
			n_s1 <= -n_ext;
			z_s1 <= HALF_TURN;
		end else begin
			e_s1 <= e_ext;
			n_s1 <= n_ext;
			z_s1 <= '0;
		end
	end

	assign ctrl_out = ctrl_s1;
	assign e_out    = e_s1;
	assign n_out    = n_s1;
	assign z_out    = z_s1;

endmodule

// ===== rtl/core/tafv_stage.sv =====
// One vectoring micro-rotation of the rotation unit, with its pipeline register.
// Depends on tafv_pkg for the arctangent table and the control type.
`timescale 1ns / 1ps

module tafv_stage #(
	parameter int VEC_WIDTH = tafv_pkg::SPEED_WIDTH_DEF + tafv_pkg::GUARD_BITS
		+ tafv_pkg::HEADROOM,
	parameter int STEP      = 0
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  tafv_pkg::ctrl_t                        ctrl_in,
	input  logic signed [VEC_WIDTH-1:0]            e_in,
	input  logic signed [VEC_WIDTH-1:0]            n_in,
	input  logic [tafv_pkg::ZACC_WIDTH-1:0]        z_in,
	output tafv_pkg::ctrl_t                        ctrl_out,
	output logic signed [VEC_WIDTH-1:0]            e_out,
	output logic signed [VEC_WIDTH-1:0]            n_out,
	output logic [tafv_pkg::ZACC_WIDTH-1:0]        z_out
);
	import tafv_pkg::*;

	localparam logic [ZACC_WIDTH-1:0] STEP_ANGLE = ATAN_TABLE[STEP];

	logic signed [VEC_WIDTH-1:0] e_shr;
	logic signed [VEC_WIDTH-1:0] n_shr;
	logic                        turn_back;
	ctrl_t                       ctrl_s;
	logic signed [VEC_WIDTH-1:0] e_s;
	logic signed [VEC_WIDTH-1:0] n_s;
	logic [ZACC_WIDTH-1:0]       z_s;

	// Arithmetic shifts round toward minus infinity, as the step requires.
	assign e_shr     = e_in >>> STEP;
	assign n_shr     = n_in >>> STEP;
	assign turn_back = (e_in > 0);

	// Control register of this step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s <= '0;
		end else begin
			ctrl_s <= ctrl_in;
		end
	end

	// Rotate towards the north axis and account for the angle turned.
	always_ff @(posedge clk) begin
		if (turn_back) begin
			z_s <= z_in + STEP_ANGLE;
			n_s <= n_in + e_shr;
			e_s <= e_in - n_shr;
		end else begin
			z_s <= z_in - STEP_ANGLE;
			n_s <= n_in - e_shr;
			e_s <= e_in + n_shr;
		end
	end

	assign ctrl_out = ctrl_s;
	assign e_out    = e_s;
	assign n_out    = n_s;
	assign z_out    = z_s;

endmodule

// ===== rtl/core/tafv_round.sv =====
// Exit stage: rounds the accumulated angle to the output width and registers the result word.
// Depends on tafv_pkg for the accumulator width and the control type.
`timescale 1ns / 1ps

module tafv_round #(
	parameter int ANGLE_WIDTH = tafv_pkg::ANGLE_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  tafv_pkg::ctrl_t                        ctrl_in,
	input  logic [tafv_pkg::ZACC_WIDTH-1:0]        z_in,
	output logic                                   done,
	output logic [ANGLE_WIDTH-1:0]                 track_angle,
	output logic                                   zero_vector
);
	import tafv_pkg::*;

	localparam logic [ZACC_WIDTH-1:0] HALF_LSB = 32'd1 << (ZACC_WIDTH - 1 - ANGLE_WIDTH);

	logic [ZACC_WIDTH-1:0]  z_rnd;
	logic                   done_s;
	logic                   zero_s;
	logic [ANGLE_WIDTH-1:0] angle_s;

	// Round half up on the kept bits; a carry out of the top wraps to north.
	assign z_rnd = z_in + HALF_LSB;

	// Strobe and flag of the result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s <= 1'b0;
			zero_s <= 1'b0;
		end else begin
			done_s <= ctrl_in.valid;
			zero_s <= ctrl_in.valid && ctrl_in.zero;
		end
	end

	// A zero vector reads as north.
	always_ff @(posedge clk) begin
		if (ctrl_in.zero) begin
			angle_s <= '0;
		end else begin
			angle_s <= z_rnd[ZACC_WIDTH-1 -: ANGLE_WIDTH];
		end
	end

	assign done        = done_s;
	assign zero_vector = zero_s;
	assign track_angle = angle_s;

endmodule

// ===== rtl/core/track_angle_from_velocity.sv =====
// Top level of the track angle block: entry stage, chain of micro-rotations, rounding stage.
// Depends on tafv_pkg, tafv_prep, tafv_stage, tafv_round and assert_macros.svh.
//
//   Channel   Handshake           Payload
//   input     start / busy        east_speed, north_speed
//   result    done (strobe)       track_angle, zero_vector
//
// A word is taken on every cycle in which start is high; busy stays low.
// Each word passes through the registers of one entry stage, one stage per micro-rotation
// (30 of them) and one rounding stage.
// The result is shown for one cycle with done; nothing holds the pipeline.
// Reset clears only the control bits (valid and zero) of the stages; words in flight are dropped.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module track_angle_from_velocity #(
	parameter int SPEED_WIDTH = tafv_pkg::SPEED_WIDTH_DEF,
	parameter int ANGLE_WIDTH = tafv_pkg::ANGLE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [SPEED_WIDTH-1:0] east_speed,
	input  logic signed [SPEED_WIDTH-1:0] north_speed,
	output logic                          done,
	output logic [ANGLE_WIDTH-1:0]        track_angle,
	output logic                          zero_vector
);
	import tafv_pkg::*;

	localparam int VEC_WIDTH = SPEED_WIDTH + GUARD_BITS + HEADROOM;
	localparam int LATENCY   = CORDIC_STEPS + 2;

	ctrl_t                       ctrl_chain [0:CORDIC_STEPS];
	logic signed [VEC_WIDTH-1:0] e_chain    [0:CORDIC_STEPS];
	logic signed [VEC_WIDTH-1:0] n_chain    [0:CORDIC_STEPS];
	logic [ZACC_WIDTH-1:0]       z_chain    [0:CORDIC_STEPS];

	// The pipeline never stalls, so a word is always taken.
	assign busy = 1'b0;

	// Entry stage.
	tafv_prep #(
		.SPEED_WIDTH (SPEED_WIDTH),
		.VEC_WIDTH   (VEC_WIDTH)
	) u_prep (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (start && !busy),
		.east_speed  (east_speed),
		.north_speed (north_speed),
		.ctrl_out    (ctrl_chain[0]),
		.e_out       (e_chain[0]),
		.n_out       (n_chain[0]),
		.z_out       (z_chain[0])
	);

	// One register stage for each micro-rotation.
	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
		tafv_stage #(
			.VEC_WIDTH (VEC_WIDTH),
			.STEP      (g)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl_in  (ctrl_chain[g]),
			.e_in     (e_chain[g]),
			.n_in     (n_chain[g]),
			.z_in     (z_chain[g]),
			.ctrl_out (ctrl_chain[g+1]),
			.e_out    (e_chain[g+1]),
			.n_out    (n_chain[g+1]),
			.z_out    (z_chain[g+1])
		);
	end

	// Rounding stage and result word.
	tafv_round #(
		.ANGLE_WIDTH (ANGLE_WIDTH)
	) u_round (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl_in     (ctrl_chain[CORDIC_STEPS]),
		.z_in        (z_chain[CORDIC_STEPS]),
		.done        (done),
		.track_angle (track_angle),
		.zero_vector (zero_vector)
	);

	// Every word taken comes out at done once it has passed through the whole pipeline.
	`ASSERT_DELAYED(a_latency, clk, arst_n, start && !busy, LATENCY, done)
	// The zero flag is only raised on a result word, and then the angle is north.
	`ASSERT_IMPLIES(a_zero_strobe, clk, arst_n, zero_vector, done)
	`ASSERT_IMPLIES(a_zero_north, clk, arst_n, done && zero_vector, track_angle == '0)
	// The zero marker never travels without a valid word.
	`ASSERT_IMPLIES(a_zero_valid, clk, arst_n, ctrl_chain[CORDIC_STEPS].zero,
		ctrl_chain[CORDIC_STEPS].valid)

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for track_angle_from_velocity: drives velocity words through start/busy
// and checks every strobed track angle against a bit-exact rotation-unit predictor.
// Depends on tafv_pkg (widths) and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;

	import tafv_pkg::*;

	localparam int SPEED_W = SPEED_WIDTH_DEF;
	localparam int ANGLE_W = ANGLE_WIDTH_DEF;

	// Arithmetic of the rotation unit, held by the bench independently of the RTL.
	localparam int ROT_STEPS = 30;
	localparam int ROT_GUARD = 24;
	localparam logic [31:0] PI_COUNTS = 32'h8000_0000;
	localparam logic [31:0] ARCTAN_STEPS [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	localparam int RANDOM_WORDS = 850;
	localparam int PIPE_DEPTH   = 32;

	typedef struct {
		logic [ANGLE_W-1:0] angle;
		logic               zero;
	} heading_t;

	// Holds the headings still owed by the block and checks each one as it arrives.
	class heading_scoreboard;
		heading_t pending_headings[$];
		int       fails;
		int       words;
		int       zero_words;
		int       checked;

		// Full-circle arctangent by vectoring micro-rotations, clockwise from north.
		function heading_t heading_of(logic signed [SPEED_W-1:0] east_in,
			logic signed [SPEED_W-1:0] north_in);
			longint      e;
			longint      n;
			longint      e_shift;
			longint      n_shift;
			logic [31:0] z;
			logic [31:0] rounded;
			heading_t    h;
			if (east_in == 0 && north_in == 0) begin
				h.angle = '0;
				h.zero  = 1'b1;
				return h;
			end
			e = longint'(east_in) * (longint'(1) << ROT_GUARD);
			n = longint'(north_in) * (longint'(1) << ROT_GUARD);
			z = '0;
			// A southerly vector is turned through half a circle first.
			if (n < 0) begin
				n = -n;
				e = -e;
				z = PI_COUNTS;
			end
			for (int i = 0; i < ROT_STEPS; i++) begin
				e_shift = e >>> i;
				n_shift = n >>> i;
				if (e > 0) begin
					z = z + ARCTAN_STEPS[i];
					n = n + e_shift;
					e = e - n_shift;
				end else begin
					z = z - ARCTAN_STEPS[i];
					n = n - e_shift;
					e = e + n_shift;
				end
			end
			// Round half up on the top bits; a carry out wraps to north.
			rounded = z + (32'd1 << (31 - ANGLE_W));
			h.angle = rounded[31 -: ANGLE_W];
			h.zero  = 1'b0;
			return h;
		endfunction

		function void note_word(logic signed [SPEED_W-1:0] east_in,
			logic signed [SPEED_W-1:0] north_in);
			heading_t h;
			h = heading_of(east_in, north_in);
			pending_headings.push_back(h);
			words++;
			if (h.zero)
				zero_words++;
		endfunction

		function void check_result(logic [ANGLE_W-1:0] angle, logic zero);
			heading_t h;
			if (pending_headings.size() == 0) begin
				$display("%0t: result with nothing outstanding, angle %0d zero_vector %0b",
					$time, angle, zero);
				fails++;
				return;
			end
			h = pending_headings.pop_front();
			checked++;
			if (angle !== h.angle) begin
				$display("%0t: track_angle mismatch, expected %0d, actual %0d",
					$time, h.angle, angle);
				fails++;
			end
			if (zero !== h.zero) begin
				$display("%0t: zero_vector mismatch, expected %0b, actual %0b",
					$time, h.zero, zero);
				fails++;
			end
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic signed [SPEED_W-1:0] east_speed;
	logic signed [SPEED_W-1:0] north_speed;
	logic                      done;
	logic [ANGLE_W-1:0]        track_angle;
	logic                      zero_vector;

	heading_scoreboard sb = new();

	track_angle_from_velocity u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.east_speed  (east_speed),
		.north_speed (north_speed),
		.done        (done),
		.track_angle (track_angle),
		.zero_vector (zero_vector)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Pre-edge sampling of both channels: a word is taken when start is high and busy low.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_word(east_speed, north_speed);
			if (done)
				sb.check_result(track_angle, zero_vector);
		end
	end

	// Offers one word after an idle gap, if one is asked for, and returns at the edge that takes it.
	task automatic send_velocity(logic signed [SPEED_W-1:0] e, logic signed [SPEED_W-1:0] n,
		int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		east_speed  <= e;
		north_speed <= n;
		do
			@(posedge clk);
		while (busy);
	endtask

	// One component: mostly full-range, sometimes an extreme or a tiny value.
	function automatic logic signed [SPEED_W-1:0] draw_speed();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: begin
				case ($urandom_range(0, 3))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return 16'sd1;
					default: return -16'sd1;
				endcase
			end
			1: return SPEED_W'($urandom_range(0, 8)) - SPEED_W'(4);
			default: return SPEED_W'($urandom());
		endcase
	endfunction

	initial begin
		int                        dir_e[$];
		int                        dir_n[$];
		int                        gap_max;
		logic signed [SPEED_W-1:0] e;
		logic signed [SPEED_W-1:0] n;

		arst_n      = 1'b0;
		start       = 1'b0;
		east_speed  = '0;
		north_speed = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: zero vector, axes, corners, unit steps and the wrap just west of north.
		dir_e = {0, 32767, -32768, 0, 0, 32767, -32768, 32767, -32768, 1, -1, 0, 0,
			1, -1, 1, -1, 32767, 32767, -32768, -1, -1, -2, 1, 0};
		dir_n = {0, 0, 0, 32767, -32768, 32767, -32768, -32768, 32767, 0, 0, 1, -1,
			1, -1, -1, 1, 1, -1, -1, 32767, 20000, 32767, -32768, 0};
		foreach (dir_e[k])
			send_velocity(SPEED_W'(dir_e[k]), SPEED_W'(dir_n[k]), (k % 3 == 0) ? 2 : 0);

		// Random words in runs of fifty: some runs back to back, others with random gaps.
		gap_max = 10;
		for (int k = 0; k < RANDOM_WORDS; k++) begin
			if (k % 50 == 0)
				gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
			case ($urandom_range(0, 9))
				0: begin
					e = '0;
					n = '0;
				end
				1: begin
					e = '0;
					n = draw_speed();
				end
				2: begin
					e = draw_speed();
					n = '0;
				end
				3: begin
					// Just west of north, where rounding may carry round to zero.
					e = -SPEED_W'($urandom_range(1, 3));
					n = SPEED_W'($urandom_range(8000, 32767));
				end
				default: begin
					e = draw_speed();
					n = draw_speed();
				end
			endcase
			send_velocity(e, n, $urandom_range(0, gap_max));
		end
		start <= 1'b0;

		// Drain the pipeline, then keep watching for stray strobes.
		while (sb.pending_headings.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 8) @(posedge clk);

		$display("Run covered %0d velocity words (%0d zero vectors); %0d headings checked.",
			sb.words, sb.zero_words, sb.checked);
		if (sb.fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("Timed out with %0d headings outstanding.", sb.pending_headings.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/tafv_pkg.sv
rtl/core/tafv_prep.sv
rtl/core/tafv_stage.sv
rtl/core/tafv_round.sv
rtl/core/track_angle_from_velocity.sv
test/tb_top.sv
